@@ design/cpa_pkg.sv @@
package cpa_pkg;

   localparam int SUM_BITS   = 40;
   localparam int COUNT_BITS = 9;
   localparam int STEP_BITS  = $clog2(SUM_BITS);
   localparam int ELAPSED_BITS = 17;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_EDGE  = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   localparam logic CSR_SAMPLES = 1'b0;
   localparam logic CSR_TIMEOUT = 1'b1;

   localparam logic [7:0]  SAMPLES_RESET = 8'd10;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] capture_stamp;
   } req_type;

   typedef struct packed {
      logic [31:0] mean_period;
      logic [7:0]  periods_used;
      logic        short_read;
      logic        no_data;
   } rsp_type;

   typedef struct packed {
      logic                  start;
      logic [SUM_BITS-1:0]   dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic [SUM_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

endpackage

@@ design/cpa_divider.sv @@
module cpa_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  cpa_pkg::div_req_type  div_req,
   output cpa_pkg::div_rsp_type  div_rsp
);

   logic                           busy_ff, busy_in;
   logic [cpa_pkg::STEP_BITS-1:0]  step_ff, step_in;
   logic [cpa_pkg::COUNT_BITS-1:0] rem_ff, rem_in;
   logic [cpa_pkg::COUNT_BITS-1:0] divisor_ff, divisor_in;
   logic [cpa_pkg::SUM_BITS-1:0]   work_ff, work_in;
   logic [cpa_pkg::COUNT_BITS:0]   trial;
   logic                           fits;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      trial      = {rem_ff, work_ff[cpa_pkg::SUM_BITS-1]};
      fits       = trial >= {1'b0, divisor_ff};
      busy_in    = busy_ff;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      work_in    = work_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         work_in    = div_req.dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? cpa_pkg::COUNT_BITS'(trial - {1'b0, divisor_ff})
                        : trial[cpa_pkg::COUNT_BITS-1:0];
         work_in = {work_ff[cpa_pkg::SUM_BITS-2:0], fits};
         step_in = step_ff + 1'b1;
         if (step_ff == cpa_pkg::STEP_BITS'(cpa_pkg::SUM_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      work_ff    <= work_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.quotient = work_ff;

endmodule

@@ design/capture_period_averager.sv @@
// Capture period averager.
// req channel: one item per action. A start item arms a measurement and
// clears the run; edge items carry a free-running timer capture; tick items
// mark one millisecond. Edges and ticks while idle are dropped.
// rsp channel: one item per finished measurement, after n + 2 captures,
// n = max(samples_in_window, 2, DISCARD_EDGES), or on ticks > timeout_ms
// (short_read set; no_data set with a zero average if under two captures).
// csr port: index 0 samples_in_window, index 1 timeout_ms; write only
// while no measurement result is in flight.
// Start, edge and tick items that finish nothing never raise req_stall. An
// item that finishes a measurement holds req_stall while the shared
// bit-serial divider produces the 40-bit quotient, one bit per cycle; the
// result then sits in the output register until rsp_stall is low, and req
// items keep being taken meanwhile. If the output register is still full
// when the divider ends, req stays stalled until it is taken.
// Reset (synchronous) returns both registers to 10 and 1000, stops any
// measurement and empties the output register.
module capture_period_averager #(
   parameter int STAMP_BITS    = 32,
   parameter int DISCARD_EDGES = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cpa_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [15:0]      csr_wdata
);

   localparam logic [7:0] DISCARD_N = 8'(DISCARD_EDGES);
   localparam logic [cpa_pkg::COUNT_BITS-1:0] EDGE_MAX = '1;
   localparam logic [cpa_pkg::ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

   cpa_pkg::state_type state_ff, state_in;
   logic [7:0]  samples_ff, samples_in;
   logic [15:0] timeout_ff, timeout_in;

   logic                             measuring_ff, measuring_in;
   logic [STAMP_BITS-1:0]            prev_ff, prev_in;
   logic [cpa_pkg::COUNT_BITS-1:0]   edges_ff, edges_in;
   logic [cpa_pkg::SUM_BITS-1:0]     late_ff, late_in;
   logic [cpa_pkg::SUM_BITS-1:0]     early_ff, early_in;
   logic [cpa_pkg::ELAPSED_BITS-1:0] elapsed_ff, elapsed_in;

   logic        pend_short_ff, pend_short_in;
   logic        pend_nodata_ff, pend_nodata_in;
   logic [7:0]  pend_used_ff, pend_used_in;

   logic             rsp_valid_ff, rsp_valid_in;
   cpa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   cpa_pkg::div_req_type div_req;
   cpa_pkg::div_rsp_type div_rsp;

   logic                           accept;
   logic [7:0]                     n_eff;
   logic [cpa_pkg::COUNT_BITS-1:0] n_minus1, n_plus1, late_count;
   logic [cpa_pkg::COUNT_BITS:0]   n_plus2;
   logic [STAMP_BITS-1:0]          stamp, delta;
   logic [cpa_pkg::COUNT_BITS-1:0] edge_next;
   logic [cpa_pkg::ELAPSED_BITS-1:0] tick_next;
   logic [cpa_pkg::COUNT_BITS-1:0] early_count;
   logic                           load_out;

   always_comb begin
      n_eff = samples_ff;
      if (n_eff < 8'd2) n_eff = 8'd2;
      if (n_eff < DISCARD_N) n_eff = DISCARD_N;
      n_minus1   = {1'b0, n_eff} - 1'b1;
      n_plus1    = {1'b0, n_eff} + 1'b1;
      n_plus2    = {2'b00, n_eff} + 2'd2;
      late_count = n_plus1 - cpa_pkg::COUNT_BITS'(DISCARD_EDGES);
      stamp      = req_data.capture_stamp[STAMP_BITS-1:0];
      delta      = stamp - prev_ff;
      edge_next  = (edges_ff == EDGE_MAX) ? edges_ff : edges_ff + 1'b1;
      tick_next  = (elapsed_ff == ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 1'b1;
      if (edges_ff >= cpa_pkg::COUNT_BITS'(2)) begin
         early_count = (edges_ff - 1'b1 > n_minus1) ? n_minus1 : edges_ff - 1'b1;
      end else begin
         early_count = '0;
      end
   end

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != cpa_pkg::ST_IDLE);
   assign load_out  = (state_ff == cpa_pkg::ST_DIVIDE) && !div_rsp.busy &&
                      (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in       = state_ff;
      samples_in     = samples_ff;
      timeout_in     = timeout_ff;
      measuring_in   = measuring_ff;
      prev_in        = prev_ff;
      edges_in       = edges_ff;
      late_in        = late_ff;
      early_in       = early_ff;
      elapsed_in     = elapsed_ff;
      pend_short_in  = pend_short_ff;
      pend_nodata_in = pend_nodata_ff;
      pend_used_in   = pend_used_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      div_req.start    = 1'b0;
      div_req.dividend = late_ff;
      div_req.divisor  = late_count;

      if (csr_write) begin
         case (csr_index)
            cpa_pkg::CSR_SAMPLES: samples_in = csr_wdata[7:0];
            cpa_pkg::CSR_TIMEOUT: timeout_in = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      if (accept) begin
         case (req_data.action)
            cpa_pkg::ACT_START: begin
               measuring_in = 1'b1;
               prev_in      = '0;
               edges_in     = '0;
               late_in      = '0;
               early_in     = '0;
               elapsed_in   = '0;
            end
            cpa_pkg::ACT_EDGE: begin
               if (measuring_ff) begin
                  if (edges_ff != '0 && edges_ff <= n_minus1) begin
                     early_in = early_ff + cpa_pkg::SUM_BITS'(delta);
                  end
                  if (edges_ff != '0 &&
                      edges_ff >= cpa_pkg::COUNT_BITS'(DISCARD_EDGES + 1) &&
                      edges_ff <= n_plus1) begin
                     late_in = late_ff + cpa_pkg::SUM_BITS'(delta);
                  end
                  prev_in  = stamp;
                  edges_in = edge_next;
                  if ({1'b0, edge_next} >= n_plus2) begin
                     measuring_in     = 1'b0;
                     div_req.start    = 1'b1;
                     div_req.dividend = late_in;
                     div_req.divisor  = late_count;
                     pend_short_in    = 1'b0;
                     pend_nodata_in   = 1'b0;
                     pend_used_in     = late_count[8] ? 8'hFF : late_count[7:0];
                     state_in         = cpa_pkg::ST_DIVIDE;
                  end
               end
            end
            cpa_pkg::ACT_TICK: begin
               if (measuring_ff) begin
                  elapsed_in = tick_next;
                  if (tick_next > {1'b0, timeout_ff}) begin
                     measuring_in     = 1'b0;
                     div_req.start    = 1'b1;
                     div_req.dividend = early_ff;
                     div_req.divisor  = early_count;
                     pend_short_in    = 1'b1;
                     pend_nodata_in   = (early_count == '0);
                     pend_used_in     = early_count[7:0];
                     state_in         = cpa_pkg::ST_DIVIDE;
                  end
               end
            end
            default: ;
         endcase
      end

      if (load_out) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.mean_period   = pend_nodata_ff ? 32'd0 : div_rsp.quotient[31:0];
         rsp_data_in.periods_used  = pend_used_ff;
         rsp_data_in.short_read    = pend_short_ff;
         rsp_data_in.no_data       = pend_nodata_ff;
         state_in                  = cpa_pkg::ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpa_pkg::ST_IDLE;
         samples_ff   <= cpa_pkg::SAMPLES_RESET;
         timeout_ff   <= cpa_pkg::TIMEOUT_RESET;
         measuring_ff <= 1'b0;
         edges_ff     <= '0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         samples_ff   <= samples_in;
         timeout_ff   <= timeout_in;
         measuring_ff <= measuring_in;
         edges_ff     <= edges_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff        <= prev_in;
      late_ff        <= late_in;
      early_ff       <= early_in;
      pend_short_ff  <= pend_short_in;
      pend_nodata_ff <= pend_nodata_in;
      pend_used_ff   <= pend_used_in;
      rsp_data_ff    <= rsp_data_in;
   end

   cpa_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_after_divide: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == cpa_pkg::ST_DIVIDE))
      else $error("result appeared without a division");

   a_div_busy_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> state_ff == cpa_pkg::ST_DIVIDE)
      else $error("divider busy outside divide state");

   a_no_measure_in_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == cpa_pkg::ST_DIVIDE |-> !measuring_ff)
      else $error("measurement still armed while dividing");

   a_no_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_data |->
         rsp_data.short_read && rsp_data.periods_used == 8'd0 &&
         rsp_data.mean_period == 32'd0)
      else $error("no_data item with nonzero fields");

endmodule
